@@ sv/bfcrc_pkg.sv @@
package bfcrc_pkg;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_CRC   = 2'd2
    } phase_t;

    localparam logic [7:0]  CH_OPEN    = 8'h7B;
    localparam logic [7:0]  CH_CLOSE   = 8'h7D;
    localparam logic [7:0]  CH_LAST    = 8'h24;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] POLY_RESET = 16'h1021;
    localparam logic [1:0]  CRC_BYTES  = 2'd2;

    // One byte of CRC-16, MSB first, eight shift steps.
    function automatic logic [15:0] crc_update(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] r;
        r = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ poly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ sv/brace_frame_crc16_receiver.sv @@
// Brace-framed packet receiver with CRC-16 check. Bytes arrive on the rx
// channel; outside a frame every byte except '{' is dropped. From '{' through
// '}' inclusive each byte is counted and folded into a CRC-16 (MSB first,
// preset 0xFFFF, no reflection, no final xor, polynomial from cfg_data, reset
// 0x1021). The two bytes after '}' are the received CRC, high byte first; the
// second one produces one result transaction on the res channel: CRC match,
// '$' before '}' flag, frame length saturated at MAX_FRAME, overflow flag and
// both CRC values. Rate: one byte per clock. The whole per-byte update (an
// eight-step CRC fold plus the framing decision) is done in one pass between
// the state registers, so rx_ready stays high every cycle except while a
// finished result sits in the output register and res_ready is low. A result
// is visible on res_valid in the cycle after its last CRC byte is accepted.
// Write cfg_data only while the block is idle.
module brace_frame_crc16_receiver #(
    parameter int MAX_FRAME = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        crc_match,
    output logic        last_packet,
    output logic [8:0]  frame_length,
    output logic        length_overflow,
    output logic [15:0] received_crc,
    output logic [15:0] computed_crc
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_FRAME);

    // Framing state
    bfcrc_pkg::phase_t phase_reg, phase_next;
    logic [15:0]   poly_reg;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   shift_reg, shift_next;
    logic [1:0]    left_reg, left_next;
    logic          prev_last_reg, prev_last_next;   // latest frame byte was '$'
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // Output register
    logic          res_valid_reg, res_valid_next;
    logic          match_reg, last_reg, res_ovf_reg;
    logic [CW-1:0] len_reg;
    logic [15:0]   rcrc_reg, ccrc_reg;

    logic          accept;
    logic          emit;
    logic [15:0]   crc_fold;
    logic [1:0]    left_dec;

    // Accept a new byte whenever the output register is free or draining.
    assign rx_ready = !res_valid_reg || res_ready;
    assign accept   = rx_valid && rx_ready;

    always_comb
    begin
        crc_fold = bfcrc_pkg::crc_update(
            (phase_reg == bfcrc_pkg::PH_FRAME) ? crc_reg : bfcrc_pkg::CRC_PRESET,
            rx_byte, poly_reg);
        left_dec = (left_reg != 2'd0) ? left_reg - 2'd1 : 2'd0;
        shift_next     = shift_reg;
        phase_next     = phase_reg;
        crc_next       = crc_reg;
        left_next      = left_reg;
        prev_last_next = prev_last_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        emit           = 1'b0;
        if (accept) begin
            case (phase_reg)
                bfcrc_pkg::PH_FRAME:
                begin
                    crc_next = crc_fold;
                    // Saturate the length and flag the overflow.
                    if (count_reg >= COUNT_MAX) begin
                        count_next = COUNT_MAX;
                        ovf_next   = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                    if (rx_byte == bfcrc_pkg::CH_CLOSE) begin
                        phase_next = bfcrc_pkg::PH_CRC;
                        left_next  = bfcrc_pkg::CRC_BYTES;
                    end else begin
                        prev_last_next = (rx_byte == bfcrc_pkg::CH_LAST);
                    end
                end
                bfcrc_pkg::PH_CRC:
                begin
                    shift_next = {shift_reg[7:0], rx_byte};
                    left_next  = left_dec;
                    if (left_dec == 2'd0) begin
                        emit       = 1'b1;
                        phase_next = bfcrc_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    // Hunt: drop everything until an opening brace.
                    phase_next = bfcrc_pkg::PH_HUNT;
                    if (rx_byte == bfcrc_pkg::CH_OPEN) begin
                        phase_next     = bfcrc_pkg::PH_FRAME;
                        ovf_next       = 1'b0;
                        count_next     = CW'(1);
                        crc_next       = crc_fold;
                        prev_last_next = 1'b0;
                        left_next      = 2'd0;
                    end
                end
            endcase
        end
        if (emit) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= bfcrc_pkg::PH_HUNT;
            poly_reg      <= bfcrc_pkg::POLY_RESET;
            crc_reg       <= bfcrc_pkg::CRC_PRESET;
            shift_reg     <= 16'h0000;
            left_reg      <= 2'd0;
            prev_last_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            shift_reg     <= shift_next;
            left_reg      <= left_next;
            prev_last_reg <= prev_last_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we) begin
                poly_reg <= cfg_data;
            end
        end
    end

    // Result payload: load on emit, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (emit) begin
            match_reg   <= (shift_next == crc_reg);
            last_reg    <= prev_last_reg;
            len_reg     <= count_reg;
            res_ovf_reg <= ovf_reg;
            rcrc_reg    <= shift_next;
            ccrc_reg    <= crc_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign crc_match       = match_reg;
    assign last_packet     = last_reg;
    assign frame_length    = 9'(len_reg);
    assign length_overflow = res_ovf_reg;
    assign received_crc    = rcrc_reg;
    assign computed_crc    = ccrc_reg;

    // The final CRC byte must produce a result in the next cycle.
    a_emit_on_last_crc_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == bfcrc_pkg::PH_CRC && left_reg == 2'd1) |=> res_valid_reg)
        else $error("final CRC byte did not produce a result");

    // Input must stall while an untaken result is held.
    a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |-> !rx_ready)
        else $error("input accepted while result register is blocked");

    // Length counter never exceeds its saturation point.
    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("frame length counter past saturation");

    // Inside a frame at least the opening brace has been counted.
    a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bfcrc_pkg::PH_FRAME) |-> (count_reg != '0))
        else $error("frame phase with zero byte count");

endmodule
